// ----- sv/hcb_pkg.sv -----
// Shared types, constants and helpers for the detector hit cluster builder.
package hcb_pkg;

  localparam int CHANNELS          = 128;
  localparam int CH_W              = $clog2(CHANNELS);
  localparam int POS_FRACTION_BITS = 8;
  localparam int POS_W             = 15;
  localparam int SUM_W             = 64;
  localparam int ADC_W             = 16;
  localparam int QUO_W             = SUM_W + POS_FRACTION_BITS;
  localparam int PROD_W            = CH_W + ADC_W;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {
    ST_BELOW = 3'd0,
    ST_BADCH = 3'd1,
    ST_ADDED = 3'd2,
    ST_EVENT = 3'd3,
    ST_ADJ   = 3'd4,
    ST_POS   = 3'd5,
    ST_FLUSH = 3'd6
  } status_t;

  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_WIRE_CNT  = 3'd1;
  localparam logic [2:0] CFG_STRIP_CNT = 3'd2;
  localparam logic [2:0] CFG_WINDOW    = 3'd3;
  localparam logic [2:0] CFG_WEIGHTED  = 3'd4;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] pos;
  } div_rsp_t;

  // quotient with fraction bits -> saturated fixed point position
  function automatic logic [POS_W-1:0] fix_pos(input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] whole;
    whole = q >> POS_FRACTION_BITS;
    if (whole > QUO_W'(POS_MAX >> POS_FRACTION_BITS)) return POS_MAX;
    else if (q > QUO_W'(POS_MAX)) return POS_MAX;
    else return q[POS_W-1:0];
  endfunction

endpackage

// ----- sv/hcb_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, integer then fraction.
module hcb_div (
  input  logic            clk,
  input  logic            rst_n,
  input  hcb_pkg::div_req_t req,
  output hcb_pkg::div_rsp_t rsp
);
  import hcb_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [SUM_W-1:0] rem_r, num_r, den_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [SUM_W:0]   sh, diff;
  logic             take;

  assign sh   = {rem_r, num_r[SUM_W-1]};
  assign diff = sh - {1'b0, den_r};
  assign take = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      num_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[SUM_W-1:0] : sh[SUM_W-1:0];
      num_r <= {num_r[SUM_W-2:0], 1'b0};  // zeros feed the fraction bits
      quo_r <= {quo_r[QUO_W-2:0], take};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.pos  = fix_pos(quo_r);

endmodule

// ----- sv/detector_hit_cluster_builder.sv -----
// Top level of the detector hit cluster builder: sequencer, cluster state, scan.
//
// Input channel (in_*): one word per readout (op 0) or flush (op 1), taken
// when in_valid is high and in_stall low. in_stall is high while a word is
// being worked on; one word is in flight at a time.
// Result channel (out_*): exactly one word per input word, held in an output
// register until taken (out_valid high, out_stall low). The next input word is
// accepted while a result still waits there.
// Config channel (cfg_*): cfg_ready is always high; index 0 threshold, 1 wire
// channel count, 2 strip channel count, 3 time window, 4 weighted mode.
// Other indexes are ignored. Write only while idle.
// Flow: a readout that is dropped or flagged goes from S_EVAL straight to
// S_DONE; one that joins the cluster passes S_EVAL, S_ACC and S_DONE. The
// next word is taken once the block is back in S_IDLE. A close (late readout
// or flush) runs a contiguity scan over all CHANNELS entries of the hit map,
// then up to two divisions (weighted mode only) on the shared serial divider,
// wire plane first; a late readout then adds its own hit in S_ACC.
// Reset (rst_n low, synchronous) clears the cluster, counters and output, and
// loads the register defaults. A stalled receiver only delays the result.
module detector_hit_cluster_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_channel,
  input  logic [15:0] in_adc,
  input  logic [31:0] in_clock_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [14:0] out_wire_pos,
  output logic        out_wire_pos_valid,
  output logic [14:0] out_strip_pos,
  output logic        out_strip_pos_valid,
  output logic [31:0] out_event_time,
  output logic [31:0] out_events_total,
  output logic [31:0] out_adjacency_rejects_total,
  output logic [31:0] out_position_rejects_total,
  output logic [31:0] out_discarded_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hcb_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_EVAL  = 11'b000_0000_0010,
    S_ACC   = 11'b000_0000_0100,
    S_SCAN  = 11'b000_0000_1000,
    S_POSW  = 11'b000_0001_0000,
    S_WAITW = 11'b000_0010_0000,
    S_POSS  = 11'b000_0100_0000,
    S_WAITS = 11'b000_1000_0000,
    S_FIN   = 11'b001_0000_0000,
    S_DONE  = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] thr_r;
  logic [7:0]  wcc_r, scc_r;
  logic [31:0] win_r;
  logic        wavg_r;

  // captured word
  logic              op_r;
  logic [15:0]       ch_r, adc_r;
  logic [31:0]       clk_r;
  logic [PROD_W-1:0] prod_r;

  // cluster state
  logic [CHANNELS-1:0] hit_map_r;
  logic [SUM_W-1:0]    w_wsum_r, w_asum_r, s_wsum_r, s_asum_r;
  logic [ADC_W-1:0]    w_peak_r, s_peak_r;
  logic [CH_W-1:0]     w_pch_r, s_pch_r;
  logic [31:0]         start_r;
  logic                await_r;
  logic [31:0]         ev_cnt_r, adj_cnt_r, pos_cnt_r, disc_cnt_r;

  // scan
  logic [CHANNELS-1:0] scan_r;
  logic [CH_W-1:0]     idx_r;
  logic [1:0]          seen_r, ended_r, bad_r;
  logic [1:0]          seen_nxt, ended_nxt, bad_nxt;
  logic                pl;  // 0 wire, 1 strip
  logic                adj_ok;

  // result under construction
  status_t          res_st_r;
  logic [POS_W-1:0] res_wp_r, res_sp_r;
  logic             res_wv_r, res_sv_r;
  logic [31:0]      res_et_r;

  logic        out_valid_r;
  logic        out_take;

  div_req_t div_req;
  div_rsp_t div_rsp;

  hcb_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // per-word decode
  logic [31:0] start_eff, age;
  logic        is_bad, join_ok, add_wire;
  logic [SUM_W:0] wsum_add, asum_add;
  logic [SUM_W-1:0] acc_wsum, acc_asum, acc_wsat, acc_asat;
  logic [ADC_W-1:0] acc_peak;
  logic [CH_W-1:0]  acc_pch, ch_idx;
  logic             peak_upd;

  assign ch_idx    = ch_r[CH_W-1:0];
  assign start_eff = await_r ? clk_r : start_r;
  assign age       = clk_r - start_eff;
  assign join_ok   = (age < win_r);
  assign is_bad    = ({1'b0, ch_r} >= (17'(wcc_r) + 17'(scc_r))) ||
                     (ch_r >= 16'(CHANNELS));
  assign add_wire  = (ch_r < 16'(wcc_r));

  assign acc_wsum = add_wire ? w_wsum_r : s_wsum_r;
  assign acc_asum = add_wire ? w_asum_r : s_asum_r;
  assign acc_peak = add_wire ? w_peak_r : s_peak_r;
  assign acc_pch  = add_wire ? w_pch_r  : s_pch_r;
  assign wsum_add = {1'b0, acc_wsum} + (SUM_W+1)'(prod_r);
  assign asum_add = {1'b0, acc_asum} + (SUM_W+1)'(adc_r);
  assign acc_wsat = wsum_add[SUM_W] ? '1 : wsum_add[SUM_W-1:0];
  assign acc_asat = asum_add[SUM_W] ? '1 : asum_add[SUM_W-1:0];
  assign peak_upd = (adc_r > acc_peak) ||
                    (adc_r != '0 && adc_r == acc_peak && ch_idx < acc_pch);

  // contiguity tracking per plane
  assign pl = !(16'(idx_r) < 16'(wcc_r));
  always_comb begin
    seen_nxt  = seen_r;
    ended_nxt = ended_r;
    bad_nxt   = bad_r;
    if (scan_r[0]) begin
      if (ended_r[pl]) bad_nxt[pl] = 1'b1;
      seen_nxt[pl] = 1'b1;
    end else if (seen_r[pl]) begin
      ended_nxt[pl] = 1'b1;
    end
  end
  assign adj_ok = seen_r[0] && !bad_r[0] && seen_r[1] && !bad_r[1];

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = w_wsum_r;
    div_req.den   = w_asum_r;
    if (state_r == S_POSW) begin
      div_req.start = adj_ok && wavg_r && (w_asum_r != '0);
    end else if (state_r == S_POSS) begin
      div_req.num   = s_wsum_r;
      div_req.den   = s_asum_r;
      div_req.start = wavg_r && (s_asum_r != '0);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;

  // control and cluster state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= '0;
      wcc_r       <= 8'd64;
      scc_r       <= 8'd64;
      win_r       <= 32'd100;
      wavg_r      <= 1'b1;
      hit_map_r   <= '0;
      w_wsum_r    <= '0;
      w_asum_r    <= '0;
      s_wsum_r    <= '0;
      s_asum_r    <= '0;
      w_peak_r    <= '0;
      s_peak_r    <= '0;
      w_pch_r     <= '0;
      s_pch_r     <= '0;
      start_r     <= '0;
      await_r     <= 1'b1;
      ev_cnt_r    <= '0;
      adj_cnt_r   <= '0;
      pos_cnt_r   <= '0;
      disc_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr_r  <= cfg_data[15:0];
          CFG_WIRE_CNT:  wcc_r  <= cfg_data[7:0];
          CFG_STRIP_CNT: scc_r  <= cfg_data[7:0];
          CFG_WINDOW:    win_r  <= cfg_data;
          CFG_WEIGHTED:  wavg_r <= cfg_data[0];
          default: ;
        endcase
      end
      // in S_DONE the output register is reloaded below
      if (out_take && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (op_r) begin
            state_r <= S_SCAN;
          end else if (adc_r < thr_r) begin
            disc_cnt_r <= disc_cnt_r + 1'b1;
            state_r    <= S_DONE;
          end else if (is_bad) begin
            state_r <= S_DONE;
          end else begin
            start_r <= start_eff;
            await_r <= 1'b0;
            state_r <= join_ok ? S_ACC : S_SCAN;
          end
        end
        S_ACC: begin
          hit_map_r[ch_idx] <= 1'b1;
          if (add_wire) begin
            w_wsum_r <= acc_wsat;
            w_asum_r <= acc_asat;
            if (peak_upd) begin
              w_peak_r <= adc_r;
              w_pch_r  <= ch_idx;
            end
          end else begin
            s_wsum_r <= acc_wsat;
            s_asum_r <= acc_asat;
            if (peak_upd) begin
              s_peak_r <= adc_r;
              s_pch_r  <= ch_idx;
            end
          end
          state_r <= S_DONE;
        end
        S_SCAN: begin
          if (idx_r == CH_W'(CHANNELS - 1)) state_r <= S_POSW;
        end
        S_POSW: begin
          if (!adj_ok) state_r <= S_FIN;
          else if (div_req.start) state_r <= S_WAITW;
          else state_r <= S_POSS;
        end
        S_WAITW: begin
          if (div_rsp.done) state_r <= S_POSS;
        end
        S_POSS: begin
          state_r <= div_req.start ? S_WAITS : S_FIN;
        end
        S_WAITS: begin
          if (div_rsp.done) state_r <= S_FIN;
        end
        S_FIN: begin
          if (!adj_ok) adj_cnt_r <= adj_cnt_r + 1'b1;
          else if (!res_wv_r && !res_sv_r) pos_cnt_r <= pos_cnt_r + 1'b1;
          else ev_cnt_r <= ev_cnt_r + 1'b1;
          hit_map_r <= '0;
          w_wsum_r  <= '0;
          w_asum_r  <= '0;
          s_wsum_r  <= '0;
          s_asum_r  <= '0;
          w_peak_r  <= '0;
          s_peak_r  <= '0;
          w_pch_r   <= '0;
          s_pch_r   <= '0;
          if (op_r) begin
            start_r <= '0;
            await_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            start_r <= clk_r;
            state_r <= S_ACC;  // late readout opens the next cluster
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload: captured word, scan, result assembly, output word
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        op_r  <= in_op;
        ch_r  <= in_channel;
        adc_r <= in_adc;
        clk_r <= in_clock_req;
      end
      S_EVAL: begin
        prod_r   <= PROD_W'(ch_idx) * PROD_W'(adc_r);
        scan_r   <= hit_map_r;
        idx_r    <= '0;
        seen_r   <= '0;
        ended_r  <= '0;
        bad_r    <= '0;
        res_wp_r <= '0;
        res_sp_r <= '0;
        res_wv_r <= 1'b0;
        res_sv_r <= 1'b0;
        res_et_r <= '0;
        if (op_r) res_st_r <= ST_FLUSH;
        else if (adc_r < thr_r) res_st_r <= ST_BELOW;
        else if (is_bad) res_st_r <= ST_BADCH;
        else res_st_r <= ST_ADDED;
      end
      S_SCAN: begin
        scan_r  <= scan_r >> 1;
        idx_r   <= idx_r + 1'b1;
        seen_r  <= seen_nxt;
        ended_r <= ended_nxt;
        bad_r   <= bad_nxt;
      end
      S_POSW: begin
        if (adj_ok && !wavg_r && w_peak_r != '0) begin
          res_wp_r <= fix_pos(QUO_W'(w_pch_r) << POS_FRACTION_BITS);
          res_wv_r <= 1'b1;
        end
      end
      S_WAITW: begin
        if (div_rsp.done) begin
          res_wp_r <= div_rsp.pos;
          res_wv_r <= 1'b1;
        end
      end
      S_POSS: begin
        if (!wavg_r && s_peak_r != '0) begin
          res_sp_r <= fix_pos(QUO_W'(s_pch_r) << POS_FRACTION_BITS);
          res_sv_r <= 1'b1;
        end
      end
      S_WAITS: begin
        if (div_rsp.done) begin
          res_sp_r <= div_rsp.pos;
          res_sv_r <= 1'b1;
        end
      end
      S_FIN: begin
        res_et_r <= start_r;
        if (!adj_ok) res_st_r <= op_r ? ST_FLUSH : ST_ADJ;
        else if (!res_wv_r && !res_sv_r) res_st_r <= op_r ? ST_FLUSH : ST_POS;
        else res_st_r <= ST_EVENT;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_status                  <= res_st_r;
          out_wire_pos                <= res_wp_r;
          out_wire_pos_valid          <= res_wv_r;
          out_strip_pos               <= res_sp_r;
          out_strip_pos_valid         <= res_sv_r;
          out_event_time              <= res_et_r;
          out_events_total            <= ev_cnt_r;
          out_adjacency_rejects_total <= adj_cnt_r;
          out_position_rejects_total  <= pos_cnt_r;
          out_discarded_total         <= disc_cnt_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- verif/hcb_checker.sv -----
// Checker for the hit cluster builder: watches all channels, predicts and compares results.
`timescale 1ns / 100ps
module hcb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_channel,
  input  logic [15:0] in_adc,
  input  logic [31:0] in_clock_req,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [14:0] out_wire_pos,
  input  logic        out_wire_pos_valid,
  input  logic [14:0] out_strip_pos,
  input  logic        out_strip_pos_valid,
  input  logic [31:0] out_event_time,
  input  logic [31:0] out_events_total,
  input  logic [31:0] out_adjacency_rejects_total,
  input  logic [31:0] out_position_rejects_total,
  input  logic [31:0] out_discarded_total,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import hcb_pkg::*;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] wire_pos;
    logic             wire_ok;
    logic [POS_W-1:0] strip_pos;
    logic             strip_ok;
    logic [31:0]      event_time;
    logic [31:0]      events;
    logic [31:0]      adj_rejects;
    logic [31:0]      pos_rejects;
    logic [31:0]      discards;
  } cluster_result_t;

  typedef struct {
    logic [63:0] wsum;
    logic [63:0] asum;
    logic [15:0] peak_adc;
    logic [6:0]  peak_ch;
  } plane_acc_t;

  cluster_result_t expected_results[$];

  // mirrored registers
  logic [15:0] thr;
  logic [7:0]  wcc, scc;
  logic [31:0] win;
  logic        weighted;

  // mirrored cluster state
  logic [CHANNELS-1:0] hits;
  plane_acc_t          wp, sp;
  logic [31:0]         start_clk;
  logic                fresh;
  logic [31:0]         n_events, n_adj, n_pos, n_disc;

  assign pending = expected_results.size();

  function automatic logic [63:0] sat64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic hit_add(int ch, logic [15:0] adc);
    plane_acc_t p;
    p = (ch < wcc) ? wp : sp;
    hits[ch] = 1'b1;
    p.wsum = sat64(p.wsum, 64'(ch) * 64'(adc));
    p.asum = sat64(p.asum, 64'(adc));
    if (adc > p.peak_adc || (adc != 0 && adc == p.peak_adc && ch < p.peak_ch)) begin
      p.peak_adc = adc;
      p.peak_ch  = ch[6:0];
    end
    if (ch < wcc) wp = p;
    else sp = p;
  endtask

  function automatic bit run_ok(int lo, int hi);
    bit seen, gap;
    seen = 0;
    gap  = 0;
    for (int c = lo; c < hi && c < CHANNELS; c++) begin
      if (hits[c]) begin
        if (gap) return 0;
        seen = 1;
      end else if (seen) begin
        gap = 1;
      end
    end
    return seen;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(logic [63:0] whole, logic [63:0] frac);
    logic [63:0] w;
    if (whole > 64'(POS_MAX >> POS_FRACTION_BITS)) return POS_MAX;
    w = (whole << POS_FRACTION_BITS) | frac;
    return (w > 64'(POS_MAX)) ? POS_MAX : w[POS_W-1:0];
  endfunction

  task automatic centroid(plane_acc_t p, output logic [POS_W-1:0] pos, output logic ok);
    logic [63:0] q, r, f;
    logic        carry;
    pos = '0;
    ok  = 1'b0;
    if (weighted) begin
      if (p.asum == 0) return;
      q = p.wsum / p.asum;
      r = p.wsum % p.asum;
      f = '0;
      for (int i = 0; i < POS_FRACTION_BITS; i++) begin
        carry = r[63];
        r = r << 1;
        f = f << 1;
        if (carry || r >= p.asum) begin
          r = r - p.asum;
          f[0] = 1'b1;
        end
      end
      pos = clamp_pos(q, f);
    end else begin
      if (p.peak_adc == 0) return;
      pos = clamp_pos(64'(p.peak_ch), 64'd0);
    end
    ok = 1'b1;
  endtask

  task automatic close_out(inout cluster_result_t e);
    e.event_time = start_clk;
    if (!run_ok(0, wcc) || !run_ok(wcc, CHANNELS)) begin
      n_adj++;
      e.status = ST_ADJ;
      return;
    end
    centroid(wp, e.wire_pos, e.wire_ok);
    centroid(sp, e.strip_pos, e.strip_ok);
    if (!e.wire_ok && !e.strip_ok) begin
      n_pos++;
      e.status = ST_POS;
    end else begin
      n_events++;
      e.status = ST_EVENT;
    end
  endtask

  task automatic wipe_cluster();
    hits = '0;
    wp   = '{default: '0};
    sp   = '{default: '0};
  endtask

  task automatic predict_word(logic op, logic [15:0] ch, logic [15:0] adc, logic [31:0] t);
    cluster_result_t e;
    e = '{status: ST_BELOW, default: '0};
    if (op) begin
      close_out(e);
      if (e.status != ST_EVENT) e.status = ST_FLUSH;
      wipe_cluster();
      start_clk = '0;
      fresh = 1'b1;
    end else if (adc < thr) begin
      n_disc++;
      e.status = ST_BELOW;
    end else if (ch >= 9'(wcc) + 9'(scc) || ch >= CHANNELS) begin
      e.status = ST_BADCH;
    end else begin
      if (fresh) begin
        start_clk = t;
        fresh = 1'b0;
      end
      if (32'(t - start_clk) < win) begin
        hit_add(int'(ch), adc);
        e.status = ST_ADDED;
      end else begin
        close_out(e);
        wipe_cluster();
        hit_add(int'(ch), adc);
        start_clk = t;
      end
    end
    e.events      = n_events;
    e.adj_rejects = n_adj;
    e.pos_rejects = n_pos;
    e.discards    = n_disc;
    expected_results.insert(expected_results.size(), e);
  endtask

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  task automatic compare_word();
    cluster_result_t e;
    if (expected_results.size() == 0) begin
      report("unexpected result word, status", out_status, 0);
      return;
    end
    e = expected_results.pop_front();
    if (out_status != e.status) report("status", out_status, e.status);
    if (out_wire_pos != e.wire_pos) report("wire_pos", out_wire_pos, e.wire_pos);
    if (out_wire_pos_valid != e.wire_ok)
      report("wire_pos_valid", out_wire_pos_valid, e.wire_ok);
    if (out_strip_pos != e.strip_pos) report("strip_pos", out_strip_pos, e.strip_pos);
    if (out_strip_pos_valid != e.strip_ok)
      report("strip_pos_valid", out_strip_pos_valid, e.strip_ok);
    if (out_event_time != e.event_time)
      report("event_time", out_event_time, e.event_time);
    if (out_events_total != e.events) report("events_total", out_events_total, e.events);
    if (out_adjacency_rejects_total != e.adj_rejects)
      report("adjacency_rejects_total", out_adjacency_rejects_total, e.adj_rejects);
    if (out_position_rejects_total != e.pos_rejects)
      report("position_rejects_total", out_position_rejects_total, e.pos_rejects);
    if (out_discarded_total != e.discards)
      report("discarded_total", out_discarded_total, e.discards);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      thr = 16'd0;
      wcc = 8'd64;
      scc = 8'd64;
      win = 32'd100;
      weighted = 1'b1;
      wipe_cluster();
      start_clk = '0;
      fresh = 1'b1;
      n_events = '0;
      n_adj = '0;
      n_pos = '0;
      n_disc = '0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) compare_word();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: thr = cfg_data[15:0];
          CFG_WIRE_CNT:  wcc = cfg_data[7:0];
          CFG_STRIP_CNT: scc = cfg_data[7:0];
          CFG_WINDOW:    win = cfg_data;
          CFG_WEIGHTED:  weighted = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_word(in_op, in_channel, in_adc, in_clock_req);
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Testbench top for the hit cluster builder: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module testbench;
  import hcb_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [15:0] in_channel = '0;
  logic [15:0] in_adc = '0;
  logic [31:0] in_clock_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [14:0] out_wire_pos, out_strip_pos;
  logic        out_wire_pos_valid, out_strip_pos_valid;
  logic [31:0] out_event_time, out_events_total, out_adjacency_rejects_total;
  logic [31:0] out_position_rejects_total, out_discarded_total;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int errors, pending;
  int send_idle = 0, recv_idle = 0;
  int quiet = 0;

  // current register values, used to aim the random clusters
  int          cur_wcc = 64, cur_scc = 64;
  logic [31:0] cur_win = 100;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  detector_hit_cluster_builder dut (.*);

  hcb_checker chk (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [15:0] ch, logic [15:0] adc, logic [31:0] t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_channel   <= ch;
    in_adc       <= adc;
    in_clock_req <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic readout(int ch, int adc, logic [31:0] t);
    send_word(1'b0, 16'(ch), 16'(adc), t);
  endtask

  task automatic flush_word();
    send_word(1'b1, 16'($urandom), 16'($urandom), $urandom);
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; load_regs drops it after the last word
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_regs(int thr, int wcc, int scc, logic [31:0] win, int wt);
    reg_write(CFG_THRESHOLD, 32'(thr));
    reg_write(CFG_WIRE_CNT, 32'(wcc));
    reg_write(CFG_STRIP_CNT, 32'(scc));
    reg_write(CFG_WINDOW, win);
    reg_write(CFG_WEIGHTED, 32'(wt));
    cfg_valid <= 1'b0;
    cur_wcc = wcc;
    cur_scc = scc;
    cur_win = win;
  endtask

  function automatic int pick_adc();
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(0, 200);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // one cluster: a contiguous run in each plane or none, maybe a gap, then a close
  task automatic random_cluster(ref int sent);
    logic [31:0] t0;
    int lo, hi, len, span, ch, off;
    int top;
    t0 = $urandom;
    top = cur_wcc + cur_scc;
    if (top > CHANNELS) top = CHANNELS;
    span = (cur_win == 0) ? 0 : ((cur_win > 32'd1000) ? 1000 : int'(cur_win) - 1);
    for (int plane = 0; plane < 2; plane++) begin
      lo = plane ? cur_wcc : 0;
      hi = plane ? top : cur_wcc;
      if (lo >= hi || $urandom_range(19) == 0) continue;
      len = $urandom_range(1, 4);
      ch = $urandom_range(lo, hi - 1);
      for (int k = 0; k < len; k++) begin
        off = (sent == 0) ? 0 : $urandom_range(0, span);
        if ($urandom_range(9) == 0) ch = ch + 2;
        else if ($urandom_range(3) != 0) ch = ch + 1;
        if (ch >= hi) ch = hi - 1;
        readout(ch, pick_adc(), (plane == 0 && k == 0) ? t0 : t0 + off);
        sent++;
      end
    end
    if ($urandom_range(1) == 0 || cur_win == '1) begin
      flush_word();
    end else begin
      readout($urandom_range(0, CHANNELS - 1), pick_adc(),
              t0 + cur_win + $urandom_range(0, 50));
    end
    sent++;
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, one accepted event first
    readout(63, 100, 32'd1000);
    readout(62, 300, 32'd1010);
    readout(64, 65535, 32'd1020);
    readout(65, 1, 32'd1099);
    readout(10, 5, 32'd1100);               // late, closes with event
    flush_word();                           // single wire hit -> adjacency
    flush_word();                           // empty cluster flush
    readout(65535, 65535, 32'hFFFF_FFFF);   // bad channel
    readout(127, 0, 32'd0);
    readout(0, 0, 32'd5);
    flush_word();                           // zero sums on both planes
    readout(3, 10, 32'hFFFF_FFF0);
    readout(5, 10, 32'h0000_0010);          // wraps, gap in wire plane
    readout(70, 10, 32'h0000_0020);
    flush_word();
    drain();
    load_regs(65535, 128, 0, 32'd0, 0);
    readout(0, 65534, 32'd0);               // below threshold
    readout(127, 65535, 32'd7);             // zero window, empty close
    readout(126, 65535, 32'd7);
    flush_word();
    drain();
    load_regs(0, 0, 128, 32'hFFFF_FFFF, 1);
    readout(0, 40, 32'hAAAA_5555);
    readout(127, 40, 32'h5555_AAAA);
    flush_word();

    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: load_regs(0, 64, 64, 32'd100, 1);
        1: load_regs(100, 32, 96, 32'hFFFF_FFFF, 0);
        2: load_regs(65535, 128, 0, 32'd0, 1);
        3: load_regs(0, 0, 128, 32'd50, 0);
        4: load_regs(20, 16, 8, 32'd1000, 1);
        default: load_regs(0, 128, 128, 32'd100, 0);
      endcase
      send_idle = (phase < 2) ? 36 : (phase < 4) ? 75 : 0;
      recv_idle = (phase < 2) ? 75 : (phase < 4) ? 36 : 0;
      while (sent < (phase + 1) * 240) begin
        if ($urandom_range(99) < 15) begin
          send_word(1'($urandom), 16'($urandom), 16'($urandom), $urandom);
          sent++;
        end else begin
          random_cluster(sent);
        end
      end
    end

    drain();
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/hcb_pkg.sv
sv/hcb_div.sv
sv/detector_hit_cluster_builder.sv
verif/hcb_checker.sv
verif/testbench.sv
